>>> design/ema_filter_bank_core_assert.svh
// Assertion macros used by the EMA filter bank top level.
`ifndef EMA_FILTER_BANK_CORE_ASSERT_SVH
`define EMA_FILTER_BANK_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk outside of reset.
`define EFB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk outside of reset.
`define EFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ema_fb_pkg.sv
// Package with the types, constants and states of the EMA filter bank.
package ema_fb_pkg;

	localparam int VALUE_BITS = 32;
	localparam int ALPHA_BITS = 16;
	localparam int UNIT_BITS = 6;
	localparam int SENSOR_BITS = 5;

	localparam int DEF_NUM_UNITS = 64;
	localparam int DEF_NUM_SENSORS = 32;

	// Difference raw - prev is exact with one extra bit.
	localparam int DIFF_W = VALUE_BITS + 1;
	localparam int PROD_W = DIFF_W + ALPHA_BITS + 1;
	localparam int QUO_W = PROD_W - ALPHA_BITS;

	// Default smoothing weight: round(0.3 * 2^ALPHA_BITS).
	localparam logic [ALPHA_BITS-1:0] ALPHA_RESET =
		ALPHA_BITS'(((64'd3 << ALPHA_BITS) + 64'd5) / 64'd10);

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic command;
		logic [UNIT_BITS-1:0] unit_index;
		logic [SENSOR_BITS-1:0] sensor_index;
		logic signed [VALUE_BITS-1:0] raw_sample;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] filtered_value;
		logic first_sample;
	} res_t;

	typedef struct packed {
		logic ld_diff;
		logic ld_mul;
	} upd_ctrl_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_DIFF,
		ST_MUL,
		ST_WRITE
	} state_t;

endpackage

>>> design/ema_fb_ram.sv
// Simple dual-port synchronous RAM with registered read.
module ema_fb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/ema_fb_update.sv
// Two-stage filter update: difference, then weighted step with round-half-up.
module ema_fb_update (
	input  logic clk,
	input  ema_fb_pkg::upd_ctrl_t ctrl,
	input  logic [ema_fb_pkg::VALUE_BITS-1:0] prev,
	input  logic [ema_fb_pkg::VALUE_BITS-1:0] raw,
	input  logic [ema_fb_pkg::ALPHA_BITS-1:0] alpha,
	output logic [ema_fb_pkg::VALUE_BITS-1:0] sum
);

	localparam int VB = ema_fb_pkg::VALUE_BITS;
	localparam int AB = ema_fb_pkg::ALPHA_BITS;
	localparam int DW = ema_fb_pkg::DIFF_W;
	localparam int PW = ema_fb_pkg::PROD_W;
	localparam int QW = ema_fb_pkg::QUO_W;

	logic signed [DW-1:0] d_s1;
	logic [VB-1:0] prev_s1;
	logic signed [PW-1:0] prod_s2;
	logic [VB-1:0] prev_s2;
	logic signed [AB:0] alpha_ext;
	logic [QW-1:0] prev_ext;
	logic [QW-1:0] quo;
	logic [QW-1:0] rnd;
	logic [QW-1:0] sum_w;

	assign alpha_ext = $signed({1'b0, alpha});

	always_ff @(posedge clk) begin
		if (ctrl.ld_diff) begin
			prev_s1 <= prev;
			d_s1 <= $signed({raw[VB-1], raw}) - $signed({prev[VB-1], prev});
		end
		if (ctrl.ld_mul) begin
			prev_s2 <= prev_s1;
			prod_s2 <= PW'(d_s1) * PW'(alpha_ext);
		end
	end

	// Adding half before the shift equals adding the top dropped bit after it.
	always_comb begin
		prev_ext = {{(QW-VB){prev_s2[VB-1]}}, prev_s2};
		quo = prod_s2[PW-1:AB];
		rnd = {{(QW-1){1'b0}}, prod_s2[AB-1]};
		sum_w = prev_ext + quo + rnd;
		sum = sum_w[VB-1:0];
	end

endmodule

>>> design/ema_filter_bank_core.sv
// Top level of the EMA filter bank: control sequencer, channel and valid-mask stores.
//
// Commands arrive on cmd (cmd_valid / cmd_stall); a word is taken at a rising edge
// with cmd_valid high and cmd_stall low. A sample command returns one result word
// on res (res_valid / res_stall); a clear command erases all channels of one unit
// and returns nothing. Commands naming a unit beyond the bank are dropped, and so are
// sample commands naming a sensor beyond it. The smoothing weight alpha is written
// through cfg_valid / cfg_ready / cfg_data; the user must write it only while the bank
// is idle, and the block itself does not enforce it. cfg_ready is always high.
// A sample walks through accept with memory read, difference, multiply, then
// write-back of both stores with the result loaded into res. The sequencer walks each
// read-modify-write through both stores before it takes the next word, so no new
// command is taken until write-back. A clear writes the mask store as it is accepted.
// After reset the valid-mask store is swept to zero, one unit per cycle; cmd_stall
// stays high during that pass.
// When res_stall holds the output word, the bank still accepts the next command
// and runs it up to write-back, where it waits until the output register frees.
`include "ema_filter_bank_core_assert.svh"

module ema_filter_bank_core #(
	parameter int NUM_UNITS = ema_fb_pkg::DEF_NUM_UNITS,
	parameter int NUM_SENSORS = ema_fb_pkg::DEF_NUM_SENSORS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  ema_fb_pkg::cmd_t cmd,
	output logic res_valid,
	input  logic res_stall,
	output ema_fb_pkg::res_t res,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [ema_fb_pkg::ALPHA_BITS-1:0] cfg_data
);

	localparam int VB = ema_fb_pkg::VALUE_BITS;
	localparam int AB = ema_fb_pkg::ALPHA_BITS;
	localparam int UNIT_AW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int CH_DEPTH = NUM_UNITS * NUM_SENSORS;
	localparam int CH_AW = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;

	ema_fb_pkg::state_t state_q, state_d;
	logic [UNIT_AW-1:0] init_cnt_q;
	logic [AB-1:0] alpha_q;
	logic [NUM_SENSORS-1:0] sensor_sel_q;
	logic [VB-1:0] raw_q;
	logic [CH_AW-1:0] ch_addr_q;
	logic [UNIT_AW-1:0] unit_q;
	logic [NUM_SENSORS-1:0] mask_new_q;
	logic first_q;
	logic res_valid_q;
	ema_fb_pkg::res_t res_q;

	logic cmd_acc;
	logic unit_ok;
	logic sensor_ok;
	logic [UNIT_AW-1:0] cmd_unit;
	logic [CH_AW-1:0] cmd_addr;
	logic [NUM_SENSORS-1:0] cmd_sel;
	logic res_free;
	logic init_last;

	logic mask_wr_en;
	logic [UNIT_AW-1:0] mask_wr_addr;
	logic [NUM_SENSORS-1:0] mask_wr_data;
	logic [NUM_SENSORS-1:0] mask_rd;
	logic val_wr_en;
	logic [VB-1:0] val_rd;
	logic [VB-1:0] upd_sum;
	logic res_load;
	ema_fb_pkg::upd_ctrl_t upd_ctrl;

	assign cmd_acc = cmd_valid && !cmd_stall;
	assign unit_ok = 32'(cmd.unit_index) < 32'(NUM_UNITS);
	assign sensor_ok = 32'(cmd.sensor_index) < 32'(NUM_SENSORS);
	assign cmd_unit = UNIT_AW'(cmd.unit_index);
	assign cmd_addr = CH_AW'(32'(cmd.unit_index) * 32'(NUM_SENSORS) + 32'(cmd.sensor_index));
	assign cmd_sel = NUM_SENSORS'(1) << cmd.sensor_index;
	assign res_free = !res_valid_q || !res_stall;
	assign init_last = init_cnt_q == UNIT_AW'(NUM_UNITS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ema_fb_pkg::ST_INIT;
			init_cnt_q <= '0;
			alpha_q <= ema_fb_pkg::ALPHA_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ema_fb_pkg::ST_INIT) begin
				init_cnt_q <= init_cnt_q + UNIT_AW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				alpha_q <= cfg_data;
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			sensor_sel_q <= cmd_sel;
			raw_q <= cmd.raw_sample;
			ch_addr_q <= cmd_addr;
			unit_q <= cmd_unit;
		end
		if (state_q == ema_fb_pkg::ST_DIFF) begin
			mask_new_q <= mask_rd | sensor_sel_q;
			first_q <= (mask_rd & sensor_sel_q) == '0;
		end
		if (res_load) begin
			res_q.filtered_value <= first_q ? raw_q : upd_sum;
			res_q.first_sample <= first_q;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_stall = 1'b1;
		mask_wr_en = 1'b0;
		mask_wr_addr = unit_q;
		mask_wr_data = mask_new_q;
		val_wr_en = 1'b0;
		res_load = 1'b0;
		upd_ctrl = '0;
		unique case (state_q)
			ema_fb_pkg::ST_INIT: begin
				mask_wr_en = 1'b1;
				mask_wr_addr = init_cnt_q;
				mask_wr_data = '0;
				if (init_last) begin
					state_d = ema_fb_pkg::ST_IDLE;
				end
			end
			ema_fb_pkg::ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid && unit_ok) begin
					if (cmd.command == ema_fb_pkg::CMD_CLEAR) begin
						mask_wr_en = 1'b1;
						mask_wr_addr = cmd_unit;
						mask_wr_data = '0;
					end else if (sensor_ok) begin
						state_d = ema_fb_pkg::ST_DIFF;
					end
				end
			end
			ema_fb_pkg::ST_DIFF: begin
				upd_ctrl.ld_diff = 1'b1;
				state_d = ema_fb_pkg::ST_MUL;
			end
			ema_fb_pkg::ST_MUL: begin
				upd_ctrl.ld_mul = 1'b1;
				state_d = ema_fb_pkg::ST_WRITE;
			end
			ema_fb_pkg::ST_WRITE: begin
				if (res_free) begin
					mask_wr_en = 1'b1;
					val_wr_en = 1'b1;
					res_load = 1'b1;
					state_d = ema_fb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ema_fb_pkg::ST_INIT;
			end
		endcase
	end

	ema_fb_ram #(
		.WIDTH(NUM_SENSORS),
		.DEPTH(NUM_UNITS),
		.AW(UNIT_AW)
	) u_mask_ram (
		.clk(clk),
		.wr_en(mask_wr_en),
		.wr_addr(mask_wr_addr),
		.wr_data(mask_wr_data),
		.rd_en(cmd_acc),
		.rd_addr(cmd_unit),
		.rd_data(mask_rd)
	);

	ema_fb_ram #(
		.WIDTH(VB),
		.DEPTH(CH_DEPTH),
		.AW(CH_AW)
	) u_value_ram (
		.clk(clk),
		.wr_en(val_wr_en),
		.wr_addr(ch_addr_q),
		.wr_data(first_q ? raw_q : upd_sum),
		.rd_en(cmd_acc),
		.rd_addr(cmd_addr),
		.rd_data(val_rd)
	);

	ema_fb_update u_update (
		.clk(clk),
		.ctrl(upd_ctrl),
		.prev(val_rd),
		.raw(raw_q),
		.alpha(alpha_q),
		.sum(upd_sum)
	);

	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res = res_q;

	`EFB_ASSERT_NOW(a_no_accept_in_init, state_q == ema_fb_pkg::ST_INIT, cmd_stall,
		"command word accepted during the mask clearing pass")
	`EFB_ASSERT_NOW(a_res_from_write, $rose(res_valid), $past(state_q) == ema_fb_pkg::ST_WRITE,
		"result word appeared without a write-back")
	`EFB_ASSERT_NEXT(a_write_delivers, state_q == ema_fb_pkg::ST_WRITE && res_free,
		res_valid && state_q == ema_fb_pkg::ST_IDLE,
		"write-back did not load the result register")
	`EFB_ASSERT_NOW(a_mask_sets_bit, state_q == ema_fb_pkg::ST_WRITE && mask_wr_en,
		(mask_wr_data & sensor_sel_q) != '0,
		"write-back left the channel marked empty")

endmodule

>>> tb/sv/ema_fb_checker.sv
`timescale 1ns / 100ps
// Checker for the EMA filter bank: predicts every filtered word and compares it on the result channel.
module ema_fb_checker
	import ema_fb_pkg::*;
#(
	parameter int NUM_UNITS = DEF_NUM_UNITS,
	parameter int NUM_SENSORS = DEF_NUM_SENSORS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [ALPHA_BITS-1:0] cfg_data,
	output int errors,
	output int pending
);

	logic [ALPHA_BITS-1:0] alpha_q;
	logic signed [VALUE_BITS-1:0] chan_value [NUM_UNITS*NUM_SENSORS];
	logic [NUM_SENSORS-1:0] chan_known [NUM_UNITS];
	res_t filtered_q [$];
	int err_count;

	// prev + alpha * (raw - prev), rounded half up; the arithmetic shift gives the floor.
	function automatic logic signed [VALUE_BITS-1:0] ema_update(
		input logic signed [VALUE_BITS-1:0] prev,
		input logic signed [VALUE_BITS-1:0] raw,
		input logic [ALPHA_BITS-1:0] weight
	);
		longint diff;
		longint w;
		diff = longint'(raw) - longint'(prev);
		w = longint'(weight);
		return VALUE_BITS'(longint'(prev)
			+ ((diff * w + (longint'(1) <<< (ALPHA_BITS - 1))) >>> ALPHA_BITS));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		cmd_t c;
		int idx;
		if (!arst_n) begin
			alpha_q = ALPHA_RESET;
			foreach (chan_known[u])
				chan_known[u] = '0;
			filtered_q.delete();
			err_count = 0;
		end else begin
			// The result leaving now always belongs to an older word, so compare first.
			if (res_valid && !res_stall) begin
				got = res;
				if (filtered_q.size() == 0) begin
					err_count++;
					$display("%0t: result word with nothing expected, expected none, got %h",
						$time, got);
				end else begin
					want = filtered_q.pop_front();
					if (got.filtered_value !== want.filtered_value) begin
						err_count++;
						$display("%0t: filtered_value mismatch, expected %h, got %h",
							$time, want.filtered_value, got.filtered_value);
					end
					if (got.first_sample !== want.first_sample) begin
						err_count++;
						$display("%0t: first_sample mismatch, expected %b, got %b",
							$time, want.first_sample, got.first_sample);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				alpha_q = cfg_data;
			if (cmd_valid && !cmd_stall) begin
				c = cmd;
				if (c.unit_index < NUM_UNITS) begin
					if (c.command == CMD_CLEAR) begin
						chan_known[c.unit_index] = '0;
					end else if (c.sensor_index < NUM_SENSORS) begin
						idx = c.unit_index * NUM_SENSORS + c.sensor_index;
						if (chan_known[c.unit_index][c.sensor_index]) begin
							want.filtered_value = ema_update(chan_value[idx], c.raw_sample,
								alpha_q);
							want.first_sample = 1'b0;
						end else begin
							want.filtered_value = c.raw_sample;
							want.first_sample = 1'b1;
							chan_known[c.unit_index][c.sensor_index] = 1'b1;
						end
						chan_value[idx] = want.filtered_value;
						filtered_q.push_back(want);
					end
				end
			end
		end
		errors <= err_count;
		pending <= filtered_q.size();
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top of the EMA filter bank testbench: clock, reset, stimulus and verdict.
module tb_top;
	import ema_fb_pkg::*;

	localparam int ITEMS_PER_BLOCK = 242;
	localparam int RANDOM_BLOCKS = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	cmd_t cmd = '0;
	logic res_stall = 1'b0;
	logic cfg_valid = 1'b0;
	logic [ALPHA_BITS-1:0] cfg_data = '0;
	logic cmd_stall;
	logic res_valid;
	res_t res;
	logic cfg_ready;
	int errors;
	int pending;

	int send_idle_pct = 0;
	int stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int cycle_count = 0;

	ema_filter_bank_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	ema_fb_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off that lets the bank back up.
	always begin
		@(posedge clk);
		if (hold_req && !hold_done) begin
			repeat (HOLD_CYCLES) begin
				res_stall <= 1'b1;
				@(posedge clk);
			end
			hold_done <= 1'b1;
		end
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send(input cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic sample(input int unit, input int sensor, input logic [VALUE_BITS-1:0] raw);
		cmd_t c;
		c.command = CMD_SAMPLE;
		c.unit_index = UNIT_BITS'(unit);
		c.sensor_index = SENSOR_BITS'(sensor);
		c.raw_sample = raw;
		send(c);
	endtask

	task automatic clear_unit(input int unit);
		cmd_t c;
		c.command = CMD_CLEAR;
		c.unit_index = UNIT_BITS'(unit);
		c.sensor_index = SENSOR_BITS'($urandom);
		c.raw_sample = $urandom;
		send(c);
	endtask

	// A clear gives no result, so wait for the expected results and then let the bench settle.
	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [ALPHA_BITS-1:0] a);
		cfg_valid <= 1'b1;
		cfg_data <= a;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		cmd_t c;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Default weight: first samples, full-scale swings, clears.
		sample(0, 0, 32'h0001_0000);
		sample(0, 0, 32'h0002_0000);
		sample(0, 0, 32'h7FFF_FFFF);
		sample(0, 0, 32'h8000_0000);
		sample(0, 0, 32'h7FFF_FFFF);
		sample(63, 31, 32'h8000_0000);
		sample(63, 31, 32'hFFFF_FFFF);
		clear_unit(63);
		sample(63, 31, 32'h1234_5678);
		clear_unit(40);
		sample(0, 0, 32'h0000_0000);
		sample(63, 0, 32'hFFFF_8000);
		drain();

		// With a zero weight the channel holds, but a first sample is still taken.
		write_alpha('0);
		sample(0, 0, 32'h7FFF_FFFF);
		sample(1, 17, 32'hDEAD_BEEF);
		sample(1, 17, 32'h4000_0000);
		drain();

		write_alpha('1);
		sample(0, 0, 32'h8000_0000);
		sample(0, 0, 32'h7FFF_FFFF);
		sample(1, 17, 32'h0000_0001);
		clear_unit(0);
		sample(0, 0, 32'h5555_5555);
		sample(0, 0, 32'hAAAA_AAAA);
		drain();

		for (int b = 0; b < RANDOM_BLOCKS; b++) begin
			case (b)
				0: write_alpha(ALPHA_BITS'($urandom_range(1, 65534)));
				1: write_alpha(16'h8000);
				2: write_alpha('1);
				3: write_alpha(16'd1);
				default: write_alpha(ALPHA_BITS'($urandom));
			endcase
			if (b < 2) begin
				send_idle_pct = 30;
				stall_pct = 62;
			end else if (b < 4) begin
				send_idle_pct = 62;
				stall_pct = 30;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			if (b == 4)
				hold_req <= 1'b1;
			repeat (ITEMS_PER_BLOCK) begin
				// Mostly a few busy channels so filters run long chains; clears are rare.
				c.command = ($urandom_range(99) < 5) ? CMD_CLEAR : CMD_SAMPLE;
				c.unit_index = UNIT_BITS'(($urandom_range(99) < 75) ?
					$urandom_range(0, 3) : $urandom);
				c.sensor_index = SENSOR_BITS'(($urandom_range(99) < 75) ?
					$urandom_range(0, 7) : $urandom);
				case ($urandom_range(0, 5))
					0, 1: c.raw_sample = $urandom;
					2: c.raw_sample = 32'($urandom_range(0, 2097152)) - 32'd1048576;
					3: c.raw_sample = 32'h7FFF_FFFF;
					4: c.raw_sample = 32'h8000_0000;
					default: c.raw_sample = $urandom_range(0, 65535);
				endcase
				send(c);
			end
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
